@@ rtl/isd_pkg.sv @@
// Shared types and constants for the IMU stillness detector.
// No dependencies; used by every module of the block.
package isd_pkg;

  localparam int AXES     = 6;
  localparam int SAMPLE_W = 32;
  localparam int CNT_W    = 11;
  localparam int RUN_W    = 16;
  localparam int THR_W    = 34;
  localparam int SUM_W    = 34;
  localparam int CFG_W    = 34;
  localparam int IDX_W    = 2;
  localparam int IN_W     = 224;
  localparam int OUT_W    = 264;

  // divider: 4 quotient bits a cycle over a 52-bit dividend
  localparam int DIV_W    = 52;
  localparam int DIV_STEP = 4;
  localparam int DIV_ITER = DIV_W / DIV_STEP;
  localparam int ITER_W   = 4;

  localparam logic [CNT_W-1:0] COUNT_MAX = 11'h7ff;
  localparam logic [RUN_W-1:0] RUN_MAX   = 16'hffff;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [IDX_W-1:0] REG_LIMIT     = 2'd1;
  localparam logic [IDX_W-1:0] REG_WINDOW    = 2'd2;

  // request from the sequencer to every lane
  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] n;
  } lane_req_t;

endpackage

@@ rtl/isd_div.sv @@
// Unsigned restoring divider, four quotient bits per cycle.
// Depends on isd_pkg.
module isd_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [isd_pkg::DIV_W-1:0]   dividend,
  input  logic [isd_pkg::CNT_W-1:0]   divisor,
  output logic                        done,
  output logic [isd_pkg::DIV_W-1:0]   quotient
);

  logic                        busy;
  logic [isd_pkg::ITER_W-1:0]  iter;
  logic [isd_pkg::DIV_W-1:0]   dvd;
  logic [isd_pkg::CNT_W-1:0]   rem;
  logic [isd_pkg::CNT_W-1:0]   dsr;
  logic [isd_pkg::DIV_W-1:0]   dvd_next;
  logic [isd_pkg::CNT_W-1:0]   rem_next;
  logic [isd_pkg::DIV_STEP-1:0] qbits;

  // four compare-subtract steps on the narrow remainder
  always_comb begin
    logic [isd_pkg::CNT_W:0]   t;
    logic [isd_pkg::CNT_W-1:0] r;
    logic [isd_pkg::DIV_W-1:0] d;
    r = rem;
    d = dvd;
    qbits = '0;
    for (int i = 0; i < isd_pkg::DIV_STEP; i++) begin
      t = {r, d[isd_pkg::DIV_W-1]};
      d = {d[isd_pkg::DIV_W-2:0], 1'b0};
      if (t >= {1'b0, dsr}) begin
        t = t - {1'b0, dsr};
        qbits[isd_pkg::DIV_STEP-1-i] = 1'b1;
      end
      r = t[isd_pkg::CNT_W-1:0];
    end
    dvd_next = d;
    rem_next = r;
  end

  // advance one step per cycle while busy
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        iter <= '0;
      end else if (busy) begin
        iter <= iter + 1'b1;
        if (iter == isd_pkg::ITER_W'(isd_pkg::DIV_ITER - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      dvd      <= dividend;
      dsr      <= divisor;
      rem      <= '0;
      quotient <= '0;
    end else if (busy) begin
      dvd      <= dvd_next;
      rem      <= rem_next;
      quotient <= {quotient[isd_pkg::DIV_W-isd_pkg::DIV_STEP-1:0], qbits};
    end
  end

endmodule

@@ rtl/isd_lane.sv @@
// One axis lane: running mean and running variance update.
// Depends on isd_pkg and isd_div.
module isd_lane (
  input  logic                                clk,
  input  logic                                rst,
  input  isd_pkg::lane_req_t                  req,
  input  logic signed [isd_pkg::SAMPLE_W-1:0] x,
  output logic signed [isd_pkg::SAMPLE_W-1:0] mean,
  output logic        [isd_pkg::SAMPLE_W-1:0] variance,
  output logic                                done
);

  localparam logic [2:0] L_IDLE = 3'd0;
  localparam logic [2:0] L_MUL  = 3'd1;
  localparam logic [2:0] L_ABS  = 3'd2;
  localparam logic [2:0] L_DIV1 = 3'd3;
  localparam logic [2:0] L_DIFF = 3'd4;
  localparam logic [2:0] L_SQ   = 3'd5;
  localparam logic [2:0] L_VSUM = 3'd6;
  localparam logic [2:0] L_DIV2 = 3'd7;

  logic [2:0] state;
  logic signed [isd_pkg::SAMPLE_W-1:0] xs;
  logic [isd_pkg::CNT_W-1:0]           n;
  logic [isd_pkg::CNT_W-1:0]           nm1;
  logic signed [43:0]                  num;
  logic                                neg;
  logic [31:0]                         dmag;
  logic [47:0]                         sq;
  logic [42:0]                         vprod;

  logic                       div_start;
  logic [isd_pkg::DIV_W-1:0]  div_dvd;
  logic                       div_done;
  logic [isd_pkg::DIV_W-1:0]  div_quo;

  logic signed [43:0]  num_mag;
  logic signed [32:0]  diff;
  logic [isd_pkg::SAMPLE_W-1:0] qlow;

  assign num_mag = num[43] ? -num : num;
  assign diff    = 33'(xs) - 33'(mean);
  assign qlow    = div_quo[isd_pkg::SAMPLE_W-1:0];

  // feed the divider with the mean or the variance numerator
  always_comb begin
    div_start = 1'b0;
    div_dvd   = '0;
    case (state)
      L_ABS: begin
        div_start = 1'b1;
        div_dvd   = isd_pkg::DIV_W'(unsigned'(num_mag));
      end
      L_VSUM: begin
        div_start = 1'b1;
        div_dvd   = isd_pkg::DIV_W'({1'b0, sq} + {6'b0, vprod});
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  isd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (n),
    .done     (div_done),
    .quotient (div_quo)
  );

  // sequence one update
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= L_IDLE;
      done     <= 1'b0;
      mean     <= '0;
      variance <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        L_IDLE: if (req.start) state <= L_MUL;
        L_MUL:  state <= L_ABS;
        L_ABS:  state <= L_DIV1;
        L_DIV1: if (div_done) begin
          mean  <= neg ? -$signed(qlow) : $signed(qlow);
          state <= L_DIFF;
        end
        L_DIFF: state <= L_SQ;
        L_SQ:   state <= L_VSUM;
        L_VSUM: state <= L_DIV2;
        L_DIV2: if (div_done) begin
          variance <= (|div_quo[isd_pkg::DIV_W-1:isd_pkg::SAMPLE_W]) ? '1 : qlow;
          done     <= 1'b1;
          state    <= L_IDLE;
        end
        default: state <= L_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == L_IDLE && req.start) begin
      xs  <= x;
      n   <= req.n;
      nm1 <= req.n - 1'b1;
    end
    if (state == L_MUL) begin
      num <= (mean * $signed({1'b0, nm1})) + 44'(xs);
    end
    if (state == L_ABS) begin
      neg <= num[43];
    end
    // the difference magnitude never exceeds 2^32 - 1
    if (state == L_DIFF) begin
      dmag <= diff[32] ? 32'(-diff) : 32'(diff);
    end
    if (state == L_SQ) begin
      sq    <= 48'((64'(dmag) * 64'(dmag)) >> 16);
      vprod <= 43'(variance) * 43'(nm1);
    end
  end

endmodule

@@ rtl/isd_merge.sv @@
// Merge stage: accelerometer variance sum, quiet run counter, still flag.
// Depends on isd_pkg.
module isd_merge (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           upd,
  input  logic [isd_pkg::SAMPLE_W-1:0]   var_x,
  input  logic [isd_pkg::SAMPLE_W-1:0]   var_y,
  input  logic [isd_pkg::SAMPLE_W-1:0]   var_z,
  input  logic [isd_pkg::THR_W-1:0]      threshold,
  input  logic [isd_pkg::RUN_W-1:0]      limit,
  output logic [isd_pkg::SUM_W-1:0]      sum,
  output logic                           still
);

  logic [isd_pkg::RUN_W-1:0] run;
  logic [isd_pkg::RUN_W-1:0] run_next;
  logic [isd_pkg::SUM_W-1:0] sum_next;

  assign sum_next = isd_pkg::SUM_W'(var_x) + isd_pkg::SUM_W'(var_y)
                  + isd_pkg::SUM_W'(var_z);

  // clear on a loud sample, else count up and hold at the top
  always_comb begin
    if (sum_next > threshold)
      run_next = '0;
    else if (run < isd_pkg::RUN_MAX)
      run_next = run + 1'b1;
    else
      run_next = run;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run   <= '0;
      still <= 1'b0;
      sum   <= '0;
    end else if (upd) begin
      run   <= run_next;
      still <= (run_next > limit);
      sum   <= sum_next;
    end
  end

endmodule

@@ rtl/imu_still_detector.sv @@
// Top level of the IMU stillness detector: sequencer, six axis lanes, merge.
// Depends on isd_pkg, isd_lane, isd_merge.
//
//   channel   direction  payload (low bits first)
//   s_axis    in         time_tag, accel_x..z, gyro_x..z
//   m_axis    out        out_time_tag, means, accel_variance_sum, is_still
//   cfg       in         cfg_index selects threshold, limit or window
//
// Each sample runs through a multiply, two divisions in every lane
// (a start plus 13 steps of 4 quotient bits each), the difference,
// the square, the hand-off and the merge.
// All six lanes run together; the next sample is taken once they finish.
// A result waits in the output register while the next sample runs.
// Reset is synchronous; it restores the configuration registers to their defaults and clears the control state.
module imu_still_detector #(
  parameter int MAX_WINDOW = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // time_tag, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z
  input  logic [isd_pkg::IN_W-1:0]     s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // out_time_tag, mean_accel_x..z, mean_gyro_x..z, accel_variance_sum,
  // is_still, zero fill
  output logic [isd_pkg::OUT_W-1:0]    m_axis_tdata,
  input  logic                         cfg_we,
  input  logic [isd_pkg::IDX_W-1:0]    cfg_index,
  input  logic [isd_pkg::CFG_W-1:0]    cfg_data
);

  localparam logic [1:0] T_IDLE  = 2'd0;
  localparam logic [1:0] T_RUN   = 2'd1;
  localparam logic [1:0] T_MERGE = 2'd2;

  logic [1:0] state;
  logic [isd_pkg::THR_W-1:0] thr;
  logic [isd_pkg::RUN_W-1:0] limit;
  logic [isd_pkg::CNT_W-1:0] window;
  logic [isd_pkg::CNT_W-1:0] count;
  logic [isd_pkg::CNT_W-1:0] count_next;
  logic [isd_pkg::CNT_W-1:0] weff;
  logic [isd_pkg::SAMPLE_W-1:0] tag;
  logic [isd_pkg::SAMPLE_W-1:0] out_tag;
  logic [isd_pkg::AXES*isd_pkg::SAMPLE_W-1:0] out_means;
  isd_pkg::lane_req_t req;
  logic [isd_pkg::AXES-1:0] lane_done;
  logic signed [isd_pkg::SAMPLE_W-1:0] lane_mean [isd_pkg::AXES];
  logic [isd_pkg::SAMPLE_W-1:0] lane_var [isd_pkg::AXES];
  logic accept;
  logic load;
  logic [isd_pkg::SUM_W-1:0] sum;
  logic still;

  assign s_axis_tready = (state == T_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign load          = (state == T_MERGE) && (!m_axis_tvalid || m_axis_tready);

  // effective window: zero acts as one, clamp at the maximum
  always_comb begin
    weff = (window == '0) ? isd_pkg::CNT_W'(1) : window;
    if (32'(weff) > 32'(MAX_WINDOW))
      weff = isd_pkg::CNT_W'(MAX_WINDOW);
  end

  assign count_next = (count == isd_pkg::COUNT_MAX) ? count : count + 1'b1;
  assign req.start  = accept;
  assign req.n      = (count_next < weff) ? count_next : weff;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      thr    <= isd_pkg::THR_W'(65536);
      limit  <= isd_pkg::RUN_W'(100);
      window <= isd_pkg::CNT_W'(100);
    end else if (cfg_we) begin
      case (cfg_index)
        isd_pkg::REG_THRESHOLD: thr    <= cfg_data;
        isd_pkg::REG_LIMIT:     limit  <= cfg_data[isd_pkg::RUN_W-1:0];
        isd_pkg::REG_WINDOW:    window <= cfg_data[isd_pkg::CNT_W-1:0];
        default:                ;
      endcase
    end
  end

  // lanes
  for (genvar k = 0; k < isd_pkg::AXES; k++) begin : g_lane
    isd_lane u_lane (
      .clk      (clk),
      .rst      (rst),
      .req      (req),
      .x        (s_axis_tdata[(k+1)*isd_pkg::SAMPLE_W +: isd_pkg::SAMPLE_W]),
      .mean     (lane_mean[k]),
      .variance (lane_var[k]),
      .done     (lane_done[k])
    );
  end

  isd_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .upd       (load),
    .var_x     (lane_var[0]),
    .var_y     (lane_var[1]),
    .var_z     (lane_var[2]),
    .threshold (thr),
    .limit     (limit),
    .sum       (sum),
    .still     (still)
  );

  // sequencer and sample counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= T_IDLE;
      count         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      case (state)
        T_IDLE: if (accept) begin
          count <= count_next;
          state <= T_RUN;
        end
        T_RUN:   if (lane_done[0]) state <= T_MERGE;
        T_MERGE: if (load) state <= T_IDLE;
        default: state <= T_IDLE;
      endcase
      if (load)
        m_axis_tvalid <= 1'b1;
      else if (m_axis_tready)
        m_axis_tvalid <= 1'b0;
    end
  end

  // hold the time tag, then copy it and the means to the output register
  always_ff @(posedge clk) begin
    if (accept)
      tag <= s_axis_tdata[isd_pkg::SAMPLE_W-1:0];
    if (load) begin
      out_tag <= tag;
      for (int k = 0; k < isd_pkg::AXES; k++)
        out_means[k*isd_pkg::SAMPLE_W +: isd_pkg::SAMPLE_W] <= lane_mean[k];
    end
  end

  assign m_axis_tdata = {5'b0, still, sum, out_means, out_tag};

`ifndef SYNTHESIS
  a_lanes_together: assert property (@(posedge clk) disable iff (rst)
    (lane_done == '0) || (lane_done == '1))
    else $error("lanes finished out of step");

  a_done_in_run: assert property (@(posedge clk) disable iff (rst)
    (lane_done != '0) |-> (state == T_RUN))
    else $error("lane finished outside a run");

  a_accept_runs: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == T_RUN) && (count != '0))
    else $error("accepted sample did not start the lanes");
`endif

endmodule
